// ----- hdl/pab_pkg.sv -----
// Shared types and codes for the premultiplied alpha blend pipeline.
// No dependencies; every other file in hdl/ imports this package.
package pab_pkg;

    // alpha_mode codes
    localparam logic [1:0] MODE_BLEND    = 2'd0;
    localparam logic [1:0] MODE_HOLD     = 2'd1;
    localparam logic [1:0] MODE_ADDITIVE = 2'd2;

    // register byte addresses
    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_ALPHA_MODE     = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_OPACITY_ENABLE = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_OPACITY        = 4'd8;

    localparam logic [7:0] OPACITY_RESET = 8'hff;

    typedef struct packed {
        logic [1:0] alpha_mode;
        logic       opacity_enable;
        logic [7:0] opacity;
    } cfg_t;

    // input item as taken from the slave side
    typedef struct packed {
        logic        eos;
        logic [31:0] dst;
        logic [31:0] src;
    } pix_in_t;

    // after opacity scaling
    typedef struct packed {
        logic        eos;
        logic [31:0] dst;
        logic [31:0] src;
    } s1_t;

    // after destination scaling
    typedef struct packed {
        logic        eos;
        logic [31:0] src;   // scaled source, ARGB
        logic [31:0] dsc;   // (d*(255-sa))>>8 per byte, ARGB
        logic [7:0]  da;    // raw destination alpha
        logic [7:0]  dsa;   // (da*sa)>>8
    } s2_t;

endpackage

// ----- hdl/pab_cfg.sv -----
// APB register file: alpha_mode, opacity_enable, opacity.
// Depends on pab_pkg.
module pab_cfg
    import pab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_mode     <= MODE_BLEND;
            cfg_reg.opacity_enable <= 1'b0;
            cfg_reg.opacity        <= OPACITY_RESET;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_ALPHA_MODE:     cfg_reg.alpha_mode     <= pwdata[1:0];
                ADDR_OPACITY_ENABLE: cfg_reg.opacity_enable <= pwdata[0];
                ADDR_OPACITY:        cfg_reg.opacity        <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_ALPHA_MODE:     prdata = {30'd0, cfg_reg.alpha_mode};
            ADDR_OPACITY_ENABLE: prdata = {31'd0, cfg_reg.opacity_enable};
            ADDR_OPACITY:        prdata = {24'd0, cfg_reg.opacity};
            default:             prdata = 32'd0;
        endcase
    end

    a_opacity_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && paddr == ADDR_OPACITY) |=> cfg_reg.opacity == $past(pwdata[7:0]))
        else $error("opacity register not updated by write");

endmodule

// ----- hdl/pab_scale.sv -----
// Stage 1: optional opacity scaling of the four source bytes.
// Depends on pab_pkg.
module pab_scale
    import pab_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pix_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output s1_t     out_data
);

    logic        valid_reg;
    s1_t         data_reg;
    s1_t         data_next;
    logic [15:0] prod [4];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.eos = in_data.eos;
        data_next.dst = in_data.dst;
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = in_data.src[8*k +: 8] * cfg.opacity;
            data_next.src[8*k +: 8] = cfg.opacity_enable ? prod[k][15:8]
                                                         : in_data.src[8*k +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- hdl/pab_mul.sv -----
// Stage 2: destination bytes times (255 - source alpha), and da*sa for additive alpha.
// Depends on pab_pkg.
module pab_mul
    import pab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [7:0]  inv_a;
    logic [15:0] prod [4];
    logic [15:0] prod_a;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        inv_a = 8'hff - in_data.src[31:24];
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = in_data.dst[8*k +: 8] * inv_a;
            data_next.dsc[8*k +: 8] = prod[k][15:8];
        end
        prod_a         = in_data.dst[31:24] * in_data.src[31:24];
        data_next.dsa  = prod_a[15:8];
        data_next.da   = in_data.dst[31:24];
        data_next.src  = in_data.src;
        data_next.eos  = in_data.eos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ----- hdl/pab_mix.sv -----
// Stage 3: saturating add per byte and alpha mode select; this is the output register.
// Depends on pab_pkg.
module pab_mix
    import pab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  s2_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_pixel,
    output logic        out_last
);

    logic        valid_reg;
    logic [31:0] pixel_reg;
    logic        last_reg;
    logic [31:0] pixel_next;
    logic [8:0]  sum [4];
    logic [7:0]  sat [4];
    logic [9:0]  add_a;
    logic [9:0]  add_c;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum[k] = {1'b0, in_data.dsc[8*k +: 8]} + {1'b0, in_data.src[8*k +: 8]};
            sat[k] = sum[k][8] ? 8'hff : sum[k][7:0];
        end
        // additive: da + sa - (da*sa>>8), then fold 256 back to 255
        add_a = {2'b00, in_data.da} + {2'b00, in_data.src[31:24]} - {2'b00, in_data.dsa};
        add_c = add_a - {8'd0, add_a[9:8]};
        pixel_next[23:0] = {sat[2], sat[1], sat[0]};
        case (cfg.alpha_mode)
            MODE_HOLD:     pixel_next[31:24] = in_data.da;
            MODE_ADDITIVE: pixel_next[31:24] = add_c[7:0];
            default:       pixel_next[31:24] = sat[3];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pixel_reg <= pixel_next;
            last_reg  <= in_data.eos;
        end
    end

    a_hold_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cfg.alpha_mode == MODE_HOLD)
        |=> pixel_reg[31:24] == $past(in_data.da))
        else $error("hold mode did not keep destination alpha");

    a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> valid_reg && $stable(pixel_reg))
        else $error("stalled output item lost");

endmodule

// ----- hdl/premultiplied_alpha_blend_top.sv -----
// Premultiplied alpha "over" blend of ARGB8888 pixels, one item per clock while m_tready
// is high, through a three-stage pipeline. An item accepted on s_tvalid/s_tready passes
// the stage 1, 2 and 3 registers in order to m_tvalid and is held while m_tready is low.
// Stage 1 scales the source by opacity (four 8x8 multipliers), stage 2
// scales the destination by (255 - source alpha) and forms da*sa (five 8x8
// multipliers), stage 3 does the saturating adds and the alpha mode select and is
// the output register. Throughput is one item per clock as long as m_tready stays
// high; each stage holds its item under back-pressure, so s_tready drops only when
// all three stages are full. Registers sit on an APB port (alpha_mode at 0x0,
// opacity_enable at 0x4, opacity at 0x8) and must be written only while no item
// is in flight. No state is kept from one pixel to the next and no clearing pass
// runs after reset.
// Depends on pab_pkg, pab_cfg, pab_scale, pab_mul, pab_mix.
module premultiplied_alpha_blend_top
    import pab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,    // [31:0] src_pixel, [63:32] dst_pixel
    input  logic              s_tlast,    // end_of_span
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,    // [31:0] blended_pixel
    output logic              m_tlast,    // span_done
    // APB register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg;
    pix_in_t in_item;
    s1_t     s1_data;
    s2_t     s2_data;
    logic    s1_valid;
    logic    s1_ready;
    logic    s2_valid;
    logic    s2_ready;

    assign in_item.src = s_tdata[31:0];
    assign in_item.dst = s_tdata[63:32];
    assign in_item.eos = s_tlast;

    pab_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1: opacity
    pab_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // stage 2: destination weighting
    pab_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // stage 3: add, saturate, alpha select; drives the master side
    pab_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_last  (m_tlast)
    );

    // an empty output stage means every stage behind it can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // a full pipeline facing back-pressure must block the input
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted with all stages stalled");

endmodule
